/* hdl/lsmb_pkg.sv */
`default_nettype none

package lsmb_pkg;

    // geometry of the scan
    localparam int SECTORS     = 36;
    localparam int OUT_SECTORS = 14;
    localparam int MAX_SAMPLES = 4096;
    localparam int SECT_W      = $clog2(SECTORS);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int BCNT_W      = (OUT_SECTORS > 1) ? $clog2(OUT_SECTORS) : 1;

    // field widths
    localparam int START_W = 17;
    localparam int STEP_W  = 13;
    localparam int RANGE_W = 16;
    localparam int INTEN_W = 16;
    localparam int COV_W   = 8;
    localparam int DIST_W  = 13;
    localparam int MEM_W   = RANGE_W + INTEN_W;

    // angle accumulator: start plus up to MAX_SAMPLES steps, plus sign
    localparam int ANGLE_W = $clog2((1 << (START_W - 1)) + MAX_SAMPLES * (1 << (STEP_W - 1))) + 1;
    localparam int ABS_W   = ANGLE_W - 1;

    // centidegrees to degrees, by reciprocal multiply (exact below 2^30)
    localparam int DIV100_MW           = 26;
    localparam logic [DIV100_MW-1:0] DIV100_MUL = 26'd42949673;
    localparam int DIV100_SH           = 32;
    localparam int DEG_W = $clog2(((1 << ABS_W) - 1) / 100 + 1);

    // degrees to whole turns, by reciprocal multiply
    localparam int DIV360_MW           = 24;
    localparam logic [DIV360_MW-1:0] DIV360_MUL = 24'd11930465;
    localparam int DIV360_SH           = 32;
    localparam int TURN_W = $clog2(((1 << ABS_W) - 1) / 100 / 360 + 1);
    localparam int TURN_DEG = 360;
    localparam int MOD_W    = $clog2(TURN_DEG);

    // degrees within a turn to sector, exact below 1024
    localparam int SDIV_MW = 8;
    localparam logic [SDIV_MW-1:0] SDIV_MUL = 8'd205;
    localparam int SDIV_SH = 11;

    // millimetres to centimetres, exact for 16 bit inputs
    localparam int CDIV_MW = 16;
    localparam logic [CDIV_MW-1:0] CDIV_MUL = 16'd52429;
    localparam int CDIV_SH = 19;

    // clamp windows around the sensor limits
    localparam int CLAMP_LO_MM = 50;
    localparam int CLAMP_HI_MM = 1500;

    // sample queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE,
        CFG_STEP_ANGLE,
        CFG_RANGE_MIN,
        CFG_RANGE_MAX,
        CFG_COVARIANCE
    } t_cfg_idx;

    typedef struct packed {
        logic signed [START_W-1:0] start;
        logic signed [STEP_W-1:0]  step;
        logic [RANGE_W-1:0]        rmin;
        logic [RANGE_W-1:0]        rmax;
        logic [COV_W-1:0]          cov;
    } t_cfg;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [INTEN_W-1:0] intensity;
        logic               upd;
        logic               last;
        logic               emit;
    } t_meta;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        t_meta             meta;
    } t_item;

    // output order: sector (SECTORS + 6 - idx) mod SECTORS
    function automatic logic [SECT_W-1:0] burst_sector(input logic [BCNT_W-1:0] idx);
        logic [SECT_W:0] t;
        t = (SECT_W + 1)'(SECTORS + 6) - (SECT_W + 1)'(idx);
        if (t >= (SECT_W + 1)'(SECTORS)) begin
            t = t - (SECT_W + 1)'(SECTORS);
        end
        return t[SECT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/lsmb_ram.sv */
`default_nettype none

module lsmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/lsmb_front.sv */
`default_nettype none

module lsmb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsmb_pkg::t_cfg              i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lsmb_pkg::RANGE_W-1:0] i_range_mm,
    input  logic [lsmb_pkg::INTEN_W-1:0] i_intensity,
    input  logic                        i_last,
    input  logic                        i_pop,
    output logic                        o_push,
    output lsmb_pkg::t_item             o_item
);
    import lsmb_pkg::*;

    logic [QCNT_W-1:0]         r_credit;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [3:0]                r_mod10;
    logic [3:0]                n_mod10;
    logic signed [ANGLE_W-1:0] r_angle;
    logic signed [ANGLE_W-1:0] ang_use;
    logic signed [ANGLE_W-1:0] ang_mag;
    logic                      accept;
    logic                      binned;
    t_meta                     meta_in;

    // angle to sector pipeline
    logic                          r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_meta                         r_s1_meta, r_s2_meta, r_s3_meta, r_s4_meta;
    logic                          r_s1_neg, r_s2_neg, r_s3_neg;
    logic [ABS_W-1:0]              r_s1_abs;
    logic [DEG_W-1:0]              r_s2_deg, r_s3_deg;
    logic [TURN_W-1:0]             r_s3_turn;
    logic [MOD_W-1:0]              r_s4_mod;
    logic [ABS_W+DIV100_MW-1:0]    prod_deg;
    logic [DEG_W+DIV360_MW-1:0]    prod_turn;
    logic [DEG_W-1:0]              rem_deg;
    logic [MOD_W-1:0]              rem_mod;
    logic [MOD_W-1:0]              n_mod;
    logic [MOD_W+SDIV_MW-1:0]      prod_sect;

    assign o_in_ready = (r_credit != '0);
    assign accept     = i_in_valid && o_in_ready;
    assign binned     = (r_count < CNT_W'(MAX_SAMPLES));

    always_comb begin
        ang_use = (r_count == '0) ? ANGLE_W'(i_cfg.start) : r_angle;
        ang_mag = ang_use[ANGLE_W-1] ? -ang_use : ang_use;
        n_count = binned ? CNT_W'(r_count + 1'b1) : r_count;
        if (!binned) begin
            n_mod10 = r_mod10;
        end else if (r_mod10 == 4'd9) begin
            n_mod10 = '0;
        end else begin
            n_mod10 = r_mod10 + 4'd1;
        end
        meta_in.range_mm  = i_range_mm;
        meta_in.intensity = i_intensity;
        meta_in.upd       = binned && (i_intensity != '0);
        meta_in.last      = i_last;
        meta_in.emit      = (n_count != '0) && (n_mod10 == '0);
    end

    always_comb begin
        prod_deg  = (ABS_W + DIV100_MW)'(r_s1_abs) * (ABS_W + DIV100_MW)'(DIV100_MUL);
        prod_turn = (DEG_W + DIV360_MW)'(r_s2_deg) * (DEG_W + DIV360_MW)'(DIV360_MUL);
        rem_deg   = r_s3_deg - DEG_W'(r_s3_turn) * DEG_W'(TURN_DEG);
        rem_mod   = rem_deg[MOD_W-1:0];
        // negative angles count back from a full turn
        n_mod     = (r_s3_neg && rem_mod != '0) ? MOD_W'(TURN_DEG) - rem_mod : rem_mod;
        prod_sect = (MOD_W + SDIV_MW)'(r_s4_mod) * (MOD_W + SDIV_MW)'(SDIV_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit   <= QCNT_W'(QDEPTH);
            r_count    <= '0;
            r_mod10    <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_credit   <= QCNT_W'(r_credit - QCNT_W'(accept) + QCNT_W'(i_pop));
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            if (accept) begin
                if (i_last) begin
                    r_count <= '0;
                    r_mod10 <= '0;
                end else begin
                    r_count <= n_count;
                    r_mod10 <= n_mod10;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && binned) begin
            r_angle <= ang_use + ANGLE_W'(i_cfg.step);
        end
        r_s1_meta <= meta_in;
        r_s1_neg  <= ang_use[ANGLE_W-1];
        r_s1_abs  <= ang_mag[ABS_W-1:0];
        r_s2_meta <= r_s1_meta;
        r_s2_neg  <= r_s1_neg;
        r_s2_deg  <= prod_deg[DIV100_SH +: DEG_W];
        r_s3_meta <= r_s2_meta;
        r_s3_neg  <= r_s2_neg;
        r_s3_deg  <= r_s2_deg;
        r_s3_turn <= prod_turn[DIV360_SH +: TURN_W];
        r_s4_meta <= r_s3_meta;
        r_s4_mod  <= n_mod;
    end

    assign o_push        = r_s4_valid;
    assign o_item.sector = prod_sect[SDIV_SH +: SECT_W];
    assign o_item.meta   = r_s4_meta;

endmodule

`default_nettype wire

/* hdl/lsmb_queue.sv */
`default_nettype none

module lsmb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lsmb_pkg::t_item i_item,
    input  logic            i_pop,
    output lsmb_pkg::t_item o_item,
    output logic            o_empty
);
    import lsmb_pkg::*;

    t_item             r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= QPTR_W'(r_wptr + 1'b1);
            end
            if (i_pop) begin
                r_rptr <= QPTR_W'(r_rptr + 1'b1);
            end
            r_count <= QCNT_W'(r_count + QCNT_W'(i_push) - QCNT_W'(i_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_buf[r_rptr];
    assign o_empty = (r_count == '0);

    // front credits keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCNT_W'(QDEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

/* hdl/lsmb_back.sv */
`default_nettype none

module lsmb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsmb_pkg::t_cfg              i_cfg,
    input  lsmb_pkg::t_item             i_item,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lsmb_pkg::SECT_W-1:0]  o_sector_index,
    output logic [lsmb_pkg::DIST_W-1:0]  o_distance_cm,
    output logic [lsmb_pkg::COV_W-1:0]   o_covariance_out,
    output logic [lsmb_pkg::INTEN_W-1:0] o_peak_intensity,
    output logic                        o_last_out
);
    import lsmb_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_BURST
    } t_state;

    t_state             r_state;
    logic [SECTORS-1:0] r_hit;
    logic [SECTORS-1:0] n_hit;
    logic               hit_clear;

    // update stage
    logic               r_w_valid;
    t_item              r_w;
    logic               r_fwd_vld;
    logic [SECT_W-1:0]  r_fwd_sec;
    logic [MEM_W-1:0]   r_fwd_data;

    // burst: read, clamp, scale
    logic [BCNT_W-1:0]  r_bcnt;
    logic               r_rd_pend;
    logic [SECT_W-1:0]  r_rd_sec;
    logic               r_rd_hit;
    logic               r_rd_last;
    logic               r_cl_valid;
    logic [SECT_W-1:0]  r_cl_sec;
    logic               r_cl_hit;
    logic               r_cl_last;
    logic [RANGE_W-1:0] r_cl_range;
    logic [INTEN_W-1:0] r_cl_peak;
    logic               r_out_valid;
    logic [SECT_W-1:0]  r_out_sec;
    logic [DIST_W-1:0]  r_out_dist;
    logic [COV_W-1:0]   r_out_cov;
    logic [INTEN_W-1:0] r_out_peak;
    logic               r_out_last;

    logic                      pop;
    logic                      issue;
    logic                      out_fire;
    logic                      burst_end;
    logic [SECT_W-1:0]         bsec;
    logic                      ram_re;
    logic                      ram_we;
    logic [SECT_W-1:0]         ram_raddr;
    logic [MEM_W-1:0]          ram_rdata;
    logic [MEM_W-1:0]          ram_wdata;
    logic [MEM_W-1:0]          stored;
    logic                      w_hit;
    logic [RANGE_W-1:0]        cur_min, new_min, rd_min, clamped;
    logic [INTEN_W-1:0]        cur_peak, new_peak, rd_peak;
    logic [RANGE_W:0]          rd_ext, mn_ext, mx_ext;
    logic                      near_min, near_max;
    logic [RANGE_W+CDIV_MW-1:0] prod_cm;

    assign out_fire  = r_out_valid && i_out_ready;
    assign pop       = (r_state == ST_RUN) && !i_empty && !(r_w_valid && r_w.meta.last);
    assign bsec      = burst_sector(r_bcnt);
    assign issue     = (r_state == ST_BURST) && !r_rd_pend && !r_cl_valid &&
                       (!r_out_valid || out_fire);
    assign burst_end = (r_bcnt == BCNT_W'(OUT_SECTORS - 1));
    assign ram_re    = pop || issue;
    assign ram_raddr = (r_state == ST_RUN) ? i_item.sector : bsec;

    // read-modify-write, forwarding the write of the previous cycle
    always_comb begin
        w_hit     = r_hit[r_w.sector];
        stored    = (r_fwd_vld && r_fwd_sec == r_w.sector) ? r_fwd_data : ram_rdata;
        cur_min   = w_hit ? stored[MEM_W-1 -: RANGE_W] : '1;
        cur_peak  = w_hit ? stored[INTEN_W-1:0] : '0;
        new_min   = (r_w.meta.range_mm < cur_min) ? r_w.meta.range_mm : cur_min;
        new_peak  = (r_w.meta.intensity > cur_peak) ? r_w.meta.intensity : cur_peak;
        ram_we    = r_w_valid && r_w.meta.upd;
        ram_wdata = {new_min, new_peak};
    end

    // hit flags: set by each update, all cleared when a scan ends without a burst, or as its burst ends
    always_comb begin
        hit_clear = ((r_state == ST_RUN) && r_w_valid && r_w.meta.last && !r_w.meta.emit) ||
                    ((r_state == ST_BURST) && issue && burst_end);
        n_hit = r_hit;
        if (ram_we) begin
            n_hit[r_w.sector] = 1'b1;
        end
        if (hit_clear) begin
            n_hit = '0;
        end
    end

    // clamp to the sensor limits when just outside them
    always_comb begin
        rd_min   = ram_rdata[MEM_W-1 -: RANGE_W];
        rd_peak  = ram_rdata[INTEN_W-1:0];
        rd_ext   = (RANGE_W + 1)'(rd_min);
        mn_ext   = (RANGE_W + 1)'(i_cfg.rmin);
        mx_ext   = (RANGE_W + 1)'(i_cfg.rmax);
        near_min = (rd_ext < mn_ext) && (rd_ext + (RANGE_W + 1)'(CLAMP_LO_MM) > mn_ext);
        near_max = (rd_ext > mx_ext) && (rd_ext < mx_ext + (RANGE_W + 1)'(CLAMP_HI_MM));
        if (near_min) begin
            clamped = i_cfg.rmin;
        end else if (near_max) begin
            clamped = i_cfg.rmax;
        end else begin
            clamped = rd_min;
        end
        prod_cm = (RANGE_W + CDIV_MW)'(r_cl_range) * (RANGE_W + CDIV_MW)'(CDIV_MUL);
    end

    lsmb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SECTORS)
    ) u_sector_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_w.sector),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_hit       <= '0;
            r_w_valid   <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_bcnt      <= '0;
            r_rd_pend   <= 1'b0;
            r_cl_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_w_valid  <= pop;
            if (pop) begin
                r_w <= i_item;
            end
            r_fwd_vld  <= ram_we;
            r_fwd_sec  <= r_w.sector;
            r_fwd_data <= ram_wdata;
            r_hit      <= n_hit;

            case (r_state)
                ST_RUN: begin
                    if (r_w_valid && r_w.meta.last && r_w.meta.emit) begin
                        r_state <= ST_BURST;
                        r_bcnt  <= '0;
                    end
                end
                ST_BURST: begin
                    if (issue) begin
                        r_bcnt <= BCNT_W'(r_bcnt + 1'b1);
                        if (burst_end) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase

            r_rd_pend <= issue;
            if (issue) begin
                r_rd_sec  <= bsec;
                r_rd_hit  <= r_hit[bsec];
                r_rd_last <= burst_end;
            end

            r_cl_valid <= r_rd_pend;
            if (r_rd_pend) begin
                r_cl_sec   <= r_rd_sec;
                r_cl_hit   <= r_rd_hit;
                r_cl_last  <= r_rd_last;
                r_cl_range <= clamped;
                r_cl_peak  <= rd_peak;
            end

            if (r_cl_valid) begin
                r_out_valid <= 1'b1;
                r_out_sec   <= r_cl_sec;
                r_out_dist  <= r_cl_hit ? prod_cm[CDIV_SH +: DIST_W] : '0;
                r_out_cov   <= r_cl_hit ? i_cfg.cov : '0;
                r_out_peak  <= r_cl_hit ? r_cl_peak : '0;
                r_out_last  <= r_cl_last;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop            = pop;
    assign o_out_valid      = r_out_valid;
    assign o_sector_index   = r_out_sec;
    assign o_distance_cm    = r_out_dist;
    assign o_covariance_out = r_out_cov;
    assign o_peak_intensity = r_out_peak;
    assign o_last_out       = r_out_last;

    // a burst read is only issued when the result register will be free
    a_rd_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !r_out_valid)
        else $error("burst read lands on a full result register");

    a_cl_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cl_valid |-> !r_out_valid)
        else $error("clamp stage overwrites a pending result");

    a_burst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BURST) |-> (!r_w_valid && !ram_we))
        else $error("sector update during result burst");

endmodule

`default_nettype wire

/* hdl/lidar_sector_min_binner.sv */
`default_nettype none

// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------------------
// sample    | in        | i_in_valid / o_in_ready    | i_range_mm, i_intensity, i_last
// sector    | out       | o_out_valid / i_out_ready  | o_sector_index, o_distance_cm,
//           |           |                            | o_covariance_out, o_peak_intensity,
//           |           |                            | o_last_out
// config    | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// a sample request can be taken every cycle while credits remain; the front turns the angle
// into a sector by two reciprocal multiplies, a turn remainder and a sector multiply
// the back does one sector read-modify-write per cycle in run state on a 36 entry 2-port RAM
// a scan end that emits gives 14 results, each read, clamped and scaled before the next read
// samples keep being taken during that burst until the 8 entry queue and credits run out
// reset is synchronous, active low; sector contents are masked by per-sector hit flags,
// so no clearing pass is needed and the block is ready in the cycle after reset

module lidar_sector_min_binner (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [lsmb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsmb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // samples
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lsmb_pkg::RANGE_W-1:0]  i_range_mm,
    input  logic [lsmb_pkg::INTEN_W-1:0]  i_intensity,
    input  logic                         i_last,
    // sector results
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lsmb_pkg::SECT_W-1:0]   o_sector_index,
    output logic [lsmb_pkg::DIST_W-1:0]   o_distance_cm,
    output logic [lsmb_pkg::COV_W-1:0]    o_covariance_out,
    output logic [lsmb_pkg::INTEN_W-1:0]  o_peak_intensity,
    output logic                         o_last_out
);
    import lsmb_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item queue_item;
    logic  front_push;
    logic  queue_empty;
    logic  back_pop;

    // config registers; start angle only takes hold at the next scan start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start <= '0;
            r_cfg.step  <= STEP_W'(100);
            r_cfg.rmin  <= '0;
            r_cfg.rmax  <= '1;
            r_cfg.cov   <= COV_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_ANGLE: r_cfg.start <= i_cfg_data[START_W-1:0];
                CFG_STEP_ANGLE:  r_cfg.step  <= i_cfg_data[STEP_W-1:0];
                CFG_RANGE_MIN:   r_cfg.rmin  <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_MAX:   r_cfg.rmax  <= i_cfg_data[RANGE_W-1:0];
                CFG_COVARIANCE:  r_cfg.cov   <= i_cfg_data[COV_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // front: angle tracking, sample count, sector lookup, credit flow control
    lsmb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_range_mm  (i_range_mm),
        .i_intensity (i_intensity),
        .i_last      (i_last),
        .i_pop       (back_pop),
        .o_push      (front_push),
        .o_item      (front_item)
    );

    // short queue so the front keeps taking samples during a result burst
    lsmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_item  (queue_item),
        .o_empty (queue_empty)
    );

    // back: per-sector min/peak update and end-of-scan result burst
    lsmb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item           (queue_item),
        .i_empty          (queue_empty),
        .o_pop            (back_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_sector_index   (o_sector_index),
        .o_distance_cm    (o_distance_cm),
        .o_covariance_out (o_covariance_out),
        .o_peak_intensity (o_peak_intensity),
        .o_last_out       (o_last_out)
    );

endmodule

`default_nettype wire
